// ----- design/tdpf_pkg.sv -----
package tdpf_pkg;

  // Default width of the tested value.
  localparam int VALUE_WIDTH_DEF = 32;

  // Smallest prime; also the step between odd trial divisors.
  localparam int FIRST_DIVISOR = 2;

endpackage

// ----- design/tdpf_div.sv -----
module tdpf_div #(
  parameter int VALUE_WIDTH = tdpf_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [VALUE_WIDTH-1:0] remainder
);
  import tdpf_pkg::*;

  localparam int CW = $clog2(VALUE_WIDTH + 1);
  localparam logic [CW-1:0] STEPS = CW'(VALUE_WIDTH);
  localparam logic [CW-1:0] LAST  = CW'(1);

  logic                   busy;
  logic [CW-1:0]          cnt;
  logic [VALUE_WIDTH-1:0] quo;
  logic [VALUE_WIDTH-1:0] rem;
  logic [VALUE_WIDTH-1:0] dsr;
  logic [VALUE_WIDTH:0]   shifted;
  logic [VALUE_WIDTH:0]   diff;

  // Restoring division, one quotient bit per cycle.
  assign shifted = {rem, quo[VALUE_WIDTH-1]};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= STEPS;
        rem  <= '0;
        quo  <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        if (!diff[VALUE_WIDTH]) begin
          rem <= diff[VALUE_WIDTH-1:0];
          quo <= {quo[VALUE_WIDTH-2:0], 1'b1};
        end else begin
          rem <= shifted[VALUE_WIDTH-1:0];
          quo <= {quo[VALUE_WIDTH-2:0], 1'b0};
        end
        cnt <= cnt - LAST;
        if (cnt == LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

`ifndef SYNTH
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a running division");

  a_rem_below_dsr: assert property (@(posedge clk) disable iff (rst)
    done |-> (rem < dsr))
    else $error("remainder not below divisor");

  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt != '0))
    else $error("divider running with zero step count");
`endif

endmodule

// ----- design/trial_division_prime_filter.sv -----
// Trial-division prime filter.
// Request channel: value with value_valid / value_stall; a request is taken
// when value_valid is high and value_stall is low. Result channel:
// tested_value and is_prime with result_valid / result_stall; the result is
// taken when result_valid is high and result_stall is low.
// One result per request: the value unchanged and a prime flag (0 and 1 are
// not prime, 2 is prime).
// Values below 3 and even values are decided without the divider. Odd
// values run trial divisors 3, 5, 7, ... through one shared restoring
// divider; the loop stops at the first zero remainder or once the divisor
// exceeds the quotient. An odd prime n runs through about sqrt(n) / 2
// trial divisors.
// value_stall is high while a request is being tested or its result waits
// for the output register. The result sits in an output register; if it is
// still stalled when the next one is ready, the block waits until it is
// taken. A result may wait while a new request is taken. Reset drops any
// request in progress and any pending result.
module trial_division_prime_filter #(
  parameter int VALUE_WIDTH = tdpf_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic                   value_valid,
  output logic                   value_stall,
  output logic [VALUE_WIDTH-1:0] tested_value,
  output logic                   is_prime,
  output logic                   result_valid,
  input  logic                   result_stall
);
  import tdpf_pkg::*;

  localparam logic [VALUE_WIDTH-1:0] TWO   = VALUE_WIDTH'(FIRST_DIVISOR);
  localparam logic [VALUE_WIDTH-1:0] THREE = VALUE_WIDTH'(FIRST_DIVISOR + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_HOLD
  } state_t;

  state_t                 state;
  logic [VALUE_WIDTH-1:0] n;
  logic [VALUE_WIDTH-1:0] divisor;
  logic                   hold_flag;
  logic                   fin;
  logic                   fin_flag;
  logic                   out_free;
  logic                   div_start;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic [VALUE_WIDTH-1:0] div_rem;

  assign value_stall = (state != S_IDLE);
  assign div_start   = (state == S_START);
  assign out_free    = !result_valid || !result_stall;

  tdpf_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (n),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  always_comb begin
    fin      = 1'b0;
    fin_flag = 1'b0;
    case (state)
      S_IDLE: begin
        if (value_valid) begin
          if (value < TWO) begin
            fin = 1'b1;
          end else if (value == TWO) begin
            fin      = 1'b1;
            fin_flag = 1'b1;
          end else if (!value[0]) begin
            fin = 1'b1;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          // divisor past sqrt(n): no factor found
          if (divisor > div_quo) begin
            fin      = 1'b1;
            fin_flag = 1'b1;
          end else if (div_rem == '0) begin
            fin = 1'b1;
          end
        end
      end
      S_HOLD: begin
        fin      = 1'b1;
        fin_flag = hold_flag;
      end
      default: begin
        fin      = 1'b0;
        fin_flag = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && !(fin && out_free)) begin
        result_valid <= 1'b0;
      end
      if (fin && out_free) begin
        result_valid <= 1'b1;
        tested_value <= (state == S_IDLE) ? value : n;
        is_prime     <= fin_flag;
        state        <= S_IDLE;
      end else if (fin) begin
        hold_flag <= fin_flag;
        if (state == S_IDLE) begin
          n <= value;
        end
        state <= S_HOLD;
      end else begin
        case (state)
          S_IDLE: begin
            if (value_valid) begin
              n       <= value;
              divisor <= THREE;
              state   <= S_START;
            end
          end
          S_START: begin
            state <= S_DIV;
          end
          S_DIV: begin
            if (div_done) begin
              divisor <= divisor + TWO;
              state   <= S_START;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

`ifndef SYNTH
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");

  a_odd_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (divisor[0] && (divisor >= THREE)))
    else $error("trial divisor not odd or below three");

  a_hold_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD) |-> result_valid)
    else $error("holding a result with the output register empty");
`endif

endmodule
